[design/avu_pkg.sv]
`timescale 1ns / 1ps
package avu_pkg;

  localparam logic [7:0]  CHAR_TERM     = 8'h00;
  localparam logic [7:0]  CHAR_RUN_LO   = 8'hD1;
  localparam logic [7:0]  CHAR_RUN_BASE = 8'hD0;
  localparam logic [7:0]  CHAR_HIGH_LO  = 8'hA1;
  localparam logic [7:0]  HIGH_OFFSET   = 8'h51;
  localparam logic [7:0]  LOW_OFFSET    = 8'h20;

  localparam logic [3:0]  PEND_RESET    = 4'd7;
  localparam logic [3:0]  PEND_MAX      = 4'd14;
  localparam logic [3:0]  GROUP_BITS    = 4'd7;
  localparam logic [2:0]  MAX_VALS      = 3'd7;

  localparam logic [3:0]  WIDTH_RESET   = 4'd8;
  localparam logic [15:0] LIMIT_RESET   = 16'd768;

  localparam logic        REG_BITS_PER_VALUE = 1'b0;
  localparam logic        REG_OUTPUT_LIMIT   = 1'b1;

  typedef struct packed {
    logic [5:0] groups;
    logic [6:0] val;
  } avu_dec_t;

  typedef struct packed {
    logic       can;
    logic [7:0] value;
    logic [3:0] pend_next;
  } avu_ext_t;

  typedef struct packed {
    logic [6:0][7:0] values;
    logic [2:0]      value_count;
    logic            limit_reached;
    logic            string_end;
    logic [15:0]     decoded_total;
    logic            last_of_run;
  } avu_res_t;

  function automatic avu_dec_t avu_decode(input logic [7:0] c);
    avu_dec_t d;
    logic [7:0] diff;
    d.groups = 6'd1;
    d.val    = 7'd0;
    diff     = 8'd0;
    if (c >= CHAR_RUN_LO) begin
      diff     = c - CHAR_RUN_BASE;
      d.groups = diff[5:0];
    end else if (c >= CHAR_HIGH_LO) begin
      diff  = c - HIGH_OFFSET;
      d.val = diff[6:0];
    end else begin
      diff  = c - LOW_OFFSET;
      d.val = diff[6:0];
    end
    return d;
  endfunction

  // 0 acts as 1, anything above 8 acts as 8
  function automatic logic [3:0] avu_eff_width(input logic [3:0] w);
    logic [3:0] e;
    e = w;
    if (w == 4'd0) e = 4'd1;
    else if (w > 4'd8) e = 4'd8;
    return e;
  endfunction

endpackage

[design/avu_extract.sv]
`timescale 1ns / 1ps
module avu_extract
  import avu_pkg::*;
(
  input  logic [13:0] bit_buf,
  input  logic [3:0]  pend,
  input  logic [3:0]  width,
  output avu_ext_t    ext
);

  logic [13:0] shifted;
  logic [8:0]  mask_wide;

  always_comb begin
    ext.can       = (pend >= width);
    ext.pend_next = pend - width;
    shifted       = bit_buf >> ext.pend_next;
    mask_wide     = (9'd1 << width) - 9'd1;
    ext.value     = shifted[7:0] & mask_wide[7:0];
  end

endmodule

[design/avu_seq.sv]
`timescale 1ns / 1ps
module avu_seq
  import avu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_char,
  input  logic [3:0]  width,
  input  logic [15:0] limit,
  output logic        out_valid,
  input  logic        out_stall,
  output avu_res_t    out_res
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_EXTRACT, S_WRAP, S_EMIT} state_t;

  state_t          state_r, state_nxt;
  logic [13:0]     buf_r, buf_nxt;
  logic [3:0]      pend_r, pend_nxt;
  logic [15:0]     emitted_r, emitted_nxt;
  logic            stopped_r, stopped_nxt;
  logic [5:0]      groups_r, groups_nxt;
  logic [6:0]      val_r, val_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [6:0][7:0] vals_r, vals_nxt;
  logic            hit_r, hit_nxt;
  logic            term_r, term_nxt;
  logic            out_valid_r, out_valid_nxt;
  avu_res_t        out_r, out_nxt;

  avu_ext_t        ext;
  avu_dec_t        dec;
  logic [15:0]     emitted_inc;
  logic [14:0]     keep_wide;
  logic [13:0]     buf_kept;
  logic            last;

  avu_extract u_extract (
    .bit_buf (buf_r),
    .pend    (pend_r),
    .width   (width),
    .ext     (ext)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    pend_nxt      = pend_r;
    emitted_nxt   = emitted_r;
    stopped_nxt   = stopped_r;
    groups_nxt    = groups_r;
    val_nxt       = val_r;
    cnt_nxt       = cnt_r;
    vals_nxt      = vals_r;
    hit_nxt       = hit_r;
    term_nxt      = term_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    dec         = avu_decode(in_code_char);
    emitted_inc = emitted_r + 16'd1;
    keep_wide   = (15'd1 << pend_r) - 15'd1;
    buf_kept    = buf_r & keep_wide[13:0];
    last        = hit_r || (groups_r == 6'd1);

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_code_char == CHAR_TERM) begin
            term_nxt  = 1'b1;
            state_nxt = S_EMIT;
          end else if (!stopped_r) begin
            if (emitted_r >= limit) begin
              stopped_nxt = 1'b1;
            end else begin
              groups_nxt = dec.groups;
              val_nxt    = dec.val;
              term_nxt   = 1'b0;
              state_nxt  = S_LOAD;
            end
          end
        end
      end
      S_LOAD: begin
        buf_nxt   = buf_r | {7'd0, val_r};
        cnt_nxt   = 3'd0;
        vals_nxt  = '0;
        hit_nxt   = 1'b0;
        state_nxt = S_EXTRACT;
      end
      S_EXTRACT: begin
        // one value per cycle through the shared extract unit
        if (ext.can && cnt_r != MAX_VALS) begin
          pend_nxt         = ext.pend_next;
          vals_nxt[cnt_r]  = ext.value;
          cnt_nxt          = cnt_r + 3'd1;
          emitted_nxt      = emitted_inc;
          if (emitted_inc >= limit) begin
            stopped_nxt = 1'b1;
            hit_nxt     = 1'b1;
            state_nxt   = S_WRAP;
          end
        end else begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        buf_nxt   = {buf_kept[6:0], 7'd0};
        pend_nxt  = (pend_r >= GROUP_BITS) ? PEND_MAX : pend_r + GROUP_BITS;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_nxt.limit_reached = stopped_r;
          out_nxt.decoded_total = emitted_r;
          if (term_r) begin
            out_nxt.values      = '0;
            out_nxt.value_count = 3'd0;
            out_nxt.string_end  = 1'b1;
            out_nxt.last_of_run = 1'b1;
            buf_nxt     = 14'd0;
            pend_nxt    = PEND_RESET;
            emitted_nxt = 16'd0;
            stopped_nxt = 1'b0;
            term_nxt    = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            out_nxt.values      = vals_r;
            out_nxt.value_count = cnt_r;
            out_nxt.string_end  = 1'b0;
            out_nxt.last_of_run = last;
            if (last) begin
              state_nxt = S_IDLE;
            end else begin
              groups_nxt = groups_r - 6'd1;
              state_nxt  = S_LOAD;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      buf_r       <= 14'd0;
      pend_r      <= PEND_RESET;
      emitted_r   <= 16'd0;
      stopped_r   <= 1'b0;
      groups_r    <= 6'd0;
      cnt_r       <= 3'd0;
      hit_r       <= 1'b0;
      term_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      buf_r       <= buf_nxt;
      pend_r      <= pend_nxt;
      emitted_r   <= emitted_nxt;
      stopped_r   <= stopped_nxt;
      groups_r    <= groups_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
    val_r  <= val_nxt;
    vals_r <= vals_nxt;
    out_r  <= out_nxt;
  end

endmodule

[design/ascii_seven_bit_unpacker.sv]
`timescale 1ns / 1ps
// Seven-bit ASCII run-length unpacker. Each input word is one coded character;
// each 7-bit group it yields gives one output word with up to seven values of
// bits_per_value bits, MSB first. A run character gives one output word per
// group, a zero character gives one word with the string total and clears the
// state. The block takes one character, then stays busy (in_stall high) until
// its last word is loaded into the output register: each group passes
// through the load, extract, wrap and emit states, and the single shift/mask
// extract unit pulls one value per cycle, 0 to 7 per group, until no full
// value is left, seven are taken or the limit is met. A terminator goes
// straight to emit; a character that is ignored after the limit leaves the
// block idle. An output stall holds the emit state only while the output
// register is still full.
module ascii_seven_bit_unpacker
  import avu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_code_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_value_0,
  output logic [7:0]  out_value_1,
  output logic [7:0]  out_value_2,
  output logic [7:0]  out_value_3,
  output logic [7:0]  out_value_4,
  output logic [7:0]  out_value_5,
  output logic [7:0]  out_value_6,
  output logic [2:0]  out_value_count,
  output logic        out_limit_reached,
  output logic        out_string_end,
  output logic [15:0] out_decoded_total,
  output logic        out_last_of_run
);

  logic [3:0]  bits_per_value_r;
  logic [15:0] output_limit_r;
  logic [3:0]  width;
  avu_res_t    res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_per_value_r <= WIDTH_RESET;
      output_limit_r   <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BITS_PER_VALUE: bits_per_value_r <= cfg_wdata[3:0];
        REG_OUTPUT_LIMIT:   output_limit_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign width = avu_eff_width(bits_per_value_r);

  avu_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_code_char (in_code_char),
    .width        (width),
    .limit        (output_limit_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  assign out_value_0       = res.values[0];
  assign out_value_1       = res.values[1];
  assign out_value_2       = res.values[2];
  assign out_value_3       = res.values[3];
  assign out_value_4       = res.values[4];
  assign out_value_5       = res.values[5];
  assign out_value_6       = res.values[6];
  assign out_value_count   = res.value_count;
  assign out_limit_reached = res.limit_reached;
  assign out_string_end    = res.string_end;
  assign out_decoded_total = res.decoded_total;
  assign out_last_of_run   = res.last_of_run;

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench
  import avu_pkg::*;
();

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = 1'b0;
  logic [15:0] cfg_wdata    = 16'd0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_code_char = 8'd0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_value_0, out_value_1, out_value_2, out_value_3;
  logic [7:0]  out_value_4, out_value_5, out_value_6;
  logic [2:0]  out_value_count;
  logic        out_limit_reached;
  logic        out_string_end;
  logic [15:0] out_decoded_total;
  logic        out_last_of_run;

  ascii_seven_bit_unpacker uut (.*);

  always #1 clk = ~clk;

  // shadow of the unpacker's registers and string state
  logic [3:0]  sh_width_reg;
  logic [15:0] sh_limit;
  logic [13:0] sh_bits;
  int          sh_pend;
  logic [15:0] sh_emitted;
  logic        sh_stopped;

  avu_res_t    group_words_q[$];
  int          err_count  = 0;
  int          sent_items = 0;
  bit          tx_quiet   = 1'b0;
  bit          rx_quiet   = 1'b0;
  int          rx_hold    = 0;

  function automatic void compare_field(string name, int want, int have);
    if (want != have) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, have);
      err_count++;
    end
  endfunction

  task automatic clear_string();
    sh_bits    = '0;
    sh_pend    = PEND_RESET;
    sh_emitted = '0;
    sh_stopped = 1'b0;
  endtask

  // one 7-bit group through the bit buffer; sets hit when the limit is met
  task automatic unpack_group(input logic [6:0] grp, output avu_res_t r, output logic hit);
    int         w;
    int         cnt;
    logic [8:0] mask9;
    r   = '0;
    hit = 1'b0;
    cnt = 0;
    w   = (sh_width_reg == 4'd0) ? 1 : (sh_width_reg > 4'd8) ? 8 : int'(sh_width_reg);
    mask9 = (9'd1 << w) - 9'd1;
    sh_bits = sh_bits | {7'd0, grp};
    if (sh_pend > 14) sh_pend = 14;
    while (sh_pend >= w && cnt < 7 && !hit) begin
      sh_pend = sh_pend - w;
      r.values[cnt] = 8'((sh_bits >> sh_pend) & {6'd0, mask9[7:0]});
      cnt++;
      sh_emitted = sh_emitted + 16'd1;
      if (sh_emitted >= sh_limit) begin
        sh_stopped = 1'b1;
        hit = 1'b1;
      end
    end
    sh_bits = sh_bits & 14'((1 << sh_pend) - 1);
    sh_bits = sh_bits << 7;
    sh_pend = sh_pend + 7;
    if (sh_pend > 14) sh_pend = 14;
    r.value_count   = cnt[2:0];
    r.limit_reached = sh_stopped;
    r.decoded_total = sh_emitted;
  endtask

  task automatic predict_char(input logic [7:0] c);
    int         groups;
    logic [6:0] grp;
    logic       hit;
    avu_res_t   r;
    if (c == CHAR_TERM) begin
      r = '0;
      r.limit_reached = sh_stopped;
      r.string_end    = 1'b1;
      r.decoded_total = sh_emitted;
      r.last_of_run   = 1'b1;
      group_words_q = {group_words_q, r};
      clear_string();
      return;
    end
    if (sh_stopped) return;
    if (sh_emitted >= sh_limit) begin
      sh_stopped = 1'b1;
      return;
    end
    groups = 1;
    if (c >= CHAR_RUN_LO) begin
      groups = c - CHAR_RUN_BASE;
      grp    = 7'd0;
    end else if (c >= CHAR_HIGH_LO) begin
      grp = 7'(c - HIGH_OFFSET);
    end else begin
      grp = 7'(c - LOW_OFFSET);
    end
    for (int g = 0; g < groups; g++) begin
      unpack_group(grp, r, hit);
      if (hit || g == groups - 1) r.last_of_run = 1'b1;
      group_words_q = {group_words_q, r};
      if (hit) break;
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_code_char <= c;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent_items++;
    predict_char(c);
  endtask

  // wait for every expected word, then let an ignored character finish
  task automatic drain();
    in_valid <= 1'b0;
    while (group_words_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_BITS_PER_VALUE) sh_width_reg = data[3:0];
    else sh_limit = data;
  endtask

  function automatic logic [7:0] draw_code_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return 8'($urandom_range(0, 255));
    if (pick < 20) return 8'($urandom_range(8'hD1, 8'hD6));
    if (pick < 23) return 8'($urandom_range(8'hD1, 8'hFF));
    return 8'($urandom_range(1, 8'hD0));
  endfunction

  // word checker and receiver stall
  always @(posedge clk) begin : word_check
    avu_res_t want;
    avu_res_t have;
    int       hold_n;
    if (rst_n && out_valid && !out_stall) begin
      have = {out_value_6, out_value_5, out_value_4, out_value_3, out_value_2,
              out_value_1, out_value_0, out_value_count, out_limit_reached,
              out_string_end, out_decoded_total, out_last_of_run};
      if (group_words_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, have);
        err_count++;
      end else begin
        want = group_words_q.pop_front();
        for (int i = 0; i < 7; i++)
          compare_field($sformatf("value_%0d", i), want.values[i], have.values[i]);
        compare_field("value_count", want.value_count, have.value_count);
        compare_field("limit_reached", want.limit_reached, have.limit_reached);
        compare_field("string_end", want.string_end, have.string_end);
        compare_field("decoded_total", want.decoded_total, have.decoded_total);
        compare_field("last_of_run", want.last_of_run, have.last_of_run);
      end
      hold_n = rx_quiet ? 0 : $urandom_range(0, 10);
      rx_hold   <= hold_n;
      out_stall <= (hold_n != 0);
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= (rx_hold > 1);
    end
  end

  task automatic test_char_classes();
    send_char(8'h20);
    send_char(8'h01);
    send_char(8'h1F);
    send_char(8'h7F);
    send_char(8'h80);
    send_char(8'h9F);
    send_char(8'hA0);
    send_char(8'hA1);
    send_char(8'hD0);
    send_char(8'hD1);
    send_char(8'hFF);   // longest run
    send_char(CHAR_TERM);
    drain();
  endtask

  task automatic test_value_widths();
    write_reg(REG_BITS_PER_VALUE, 16'd1);
    send_char(8'h7F);
    send_char(CHAR_TERM);
    drain();
    write_reg(REG_BITS_PER_VALUE, 16'd0);   // acts as 1
    send_char(8'hD3);
    send_char(CHAR_TERM);
    drain();
    write_reg(REG_BITS_PER_VALUE, 16'hFFFF); // acts as 8
    send_char(8'hA1);
    send_char(CHAR_TERM);
    drain();
  endtask

  task automatic test_output_limit();
    // limit inside a group, then stopped characters
    write_reg(REG_BITS_PER_VALUE, 16'd1);
    write_reg(REG_OUTPUT_LIMIT, 16'd1);
    send_char(8'h7F);
    send_char(8'h41);
    send_char(CHAR_TERM);
    drain();
    write_reg(REG_OUTPUT_LIMIT, 16'd0);
    send_char(8'h41);
    send_char(CHAR_TERM);
    drain();
    // limit reached part way through a run
    write_reg(REG_OUTPUT_LIMIT, 16'd10);
    send_char(8'hFF);
    send_char(CHAR_TERM);
    drain();
    // limit lowered below what the string already holds
    write_reg(REG_BITS_PER_VALUE, 16'd8);
    write_reg(REG_OUTPUT_LIMIT, 16'd768);
    send_char(8'hD3);
    send_char(8'h41);
    drain();
    write_reg(REG_OUTPUT_LIMIT, 16'd1);
    send_char(8'h42);
    send_char(CHAR_TERM);
    drain();
  endtask

  task automatic test_random_strings();
    int         phase;
    int         len;
    logic [3:0] w;
    logic [15:0] lim;
    phase = 0;
    while (sent_items < 100) begin
      drain();
      case (phase)
        0:       w = 4'd1;
        1:       w = 4'd8;
        2:       w = 4'd0;
        3:       w = 4'd15;
        default: w = 4'($urandom_range(0, 15));
      endcase
      case (phase % 5)
        0:       lim = 16'hFFFF;
        1:       lim = 16'($urandom_range(1, 12));
        2:       lim = 16'($urandom_range(1, 200));
        3:       lim = 16'd768;
        default: lim = 16'($urandom_range(1, 65535));
      endcase
      write_reg(REG_BITS_PER_VALUE, {12'd0, w});
      write_reg(REG_OUTPUT_LIMIT, lim);
      tx_quiet = (phase % 4 == 3);
      rx_quiet = (phase % 4 == 3);
      repeat ($urandom_range(2, 3)) begin
        len = $urandom_range(1, 8);
        repeat (len) send_char(draw_code_char());
        // now and then a string runs on without its terminator
        if ($urandom_range(0, 7) != 0) send_char(CHAR_TERM);
      end
      phase++;
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    sh_width_reg = WIDTH_RESET;
    sh_limit     = LIMIT_RESET;
    clear_string();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_char_classes();
    test_value_widths();
    test_output_limit();
    test_random_strings();
    drain();
    if (err_count == 0 && group_words_q.size() == 0)
      $display("PASS ascii_seven_bit_unpacker");
    else
      $display("FAIL ascii_seven_bit_unpacker");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL ascii_seven_bit_unpacker");
    $finish;
  end

endmodule
